/* sv/phong_fragment_shade_defines.svh */
// Assertion macros shared by the checker files.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef PHONG_FRAGMENT_SHADE_DEFINES_SVH
`define PHONG_FRAGMENT_SHADE_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define PHF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the edge after the antecedent.
`define PHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/phf_pkg.sv */
`default_nettype none

package phf_pkg;

  // fixed point
  localparam int FRAC_W = 14;               // Q2.14 unit vectors
  localparam int NORM_W = 23;               // normalized magnitude, top in [2^22, 2^23)
  localparam int SQ_W   = 48;               // sum of three squares
  localparam int ROOT_W = 24;               // floor sqrt
  localparam int REM_W  = 27;               // sqrt partial remainder
  localparam int QUO_W  = FRAC_W + 1;       // quotient, at most 1.0
  localparam int NUM_W  = NORM_W + FRAC_W + 1;
  localparam int DREM_W = ROOT_W + 1;       // divider partial remainder

  // pipeline shape of the normalizer
  localparam int SQRT_PER  = 3;
  localparam int SQRT_STG  = ROOT_W / SQRT_PER;
  localparam int DIV_PER   = 3;
  localparam int DIV_STG   = QUO_W / DIV_PER;
  localparam int UNIT_LAT  = SQRT_STG + DIV_STG + 6;

  // exponent
  localparam int SHIN_W  = 6;
  localparam int POW_STG = (1 << SHIN_W) - 1;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    logic vld;
    logic nz;
  } unit_ctl_t;

  typedef enum logic [2:0] {
    CFG_LIGHT_X    = 3'd0,
    CFG_LIGHT_Y    = 3'd1,
    CFG_LIGHT_Z    = 3'd2,
    CFG_AMBIENT    = 3'd3,
    CFG_DIFFUSE    = 3'd4,
    CFG_SPECULAR   = 3'd5,
    CFG_SHININESS  = 3'd6
  } cfg_reg_t;

  localparam logic signed [15:0] LIGHT_X_RST   = 16'sd0;
  localparam logic signed [15:0] LIGHT_Y_RST   = 16'sd0;
  localparam logic signed [15:0] LIGHT_Z_RST   = 16'sd16384;
  localparam logic [15:0]        AMBIENT_RST   = 16'd9830;
  localparam logic [15:0]        DIFFUSE_RST   = 16'd13107;
  localparam logic [15:0]        SPECULAR_RST  = 16'd29491;
  localparam logic [SHIN_W-1:0]  SHININESS_RST = 6'd35;

endpackage

`default_nettype wire

/* sv/phf_unitize.sv */
`default_nettype none

// Pipelined vector normalizer: largest |c| scaled to [2^22,2^23), floor sqrt of
// the sum of squares, then round-half-up |c|*2^14/len per lane. Stages advance
// only while ce is high.
module phf_unitize
  import phf_pkg::*;
#(
  parameter int IN_W = 35
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   in_vld,
  input  logic signed [IN_W-1:0] in_vec [3],
  output unit_ctl_t              out_ctl,
  output q14_t                   out_vec [3]
);

  localparam int PosW = $clog2(IN_W);
  localparam int ShW  = NORM_W - 1;

  // stage A: magnitudes and largest
  logic [IN_W-1:0] mag_c [3];
  logic [IN_W-1:0] top_c;
  logic            a_vld;
  logic [2:0]      a_neg;
  logic [IN_W-1:0] a_mag [3];
  logic [IN_W-1:0] a_top;

  always_comb begin
    top_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + IN_W'(1)) : in_vec[i];
      if (mag_c[i] > top_c) top_c = mag_c[i];
    end
  end

  // stage B: scale by a power of two (right shifts truncate)
  logic [PosW-1:0]      pos_c;
  logic [IN_W+ShW-1:0]  wide_c [3];
  logic [NORM_W-1:0]    b_mag_c [3];
  logic                 b_vld;
  logic                 b_nz;
  logic [2:0]           b_neg;
  logic [NORM_W-1:0]    b_mag [3];

  always_comb begin
    pos_c = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (a_top[k]) pos_c = PosW'(k);
    end
    for (int i = 0; i < 3; i++) begin
      wide_c[i]  = ({{ShW{1'b0}}, a_mag[i]} << ShW) >> pos_c;
      b_mag_c[i] = wide_c[i][NORM_W-1:0];
    end
  end

  // stage C: squares
  logic                c_vld;
  logic                c_nz;
  logic [2:0]          c_neg;
  logic [NORM_W-1:0]   c_mag [3];
  logic [2*NORM_W-1:0] c_sq [3];

  // square root stages, index 0 holds the sum
  logic              s_vld  [SQRT_STG+1];
  logic              s_nz   [SQRT_STG+1];
  logic [2:0]        s_neg  [SQRT_STG+1];
  logic [NORM_W-1:0] s_mag  [SQRT_STG+1][3];
  logic [SQ_W-1:0]   s_rad  [SQRT_STG+1];
  logic [REM_W-1:0]  s_rem  [SQRT_STG+1];
  logic [ROOT_W-1:0] s_root [SQRT_STG+1];
  logic [SQ_W-1:0]   sq_rad_c  [SQRT_STG];
  logic [REM_W-1:0]  sq_rem_c  [SQRT_STG];
  logic [ROOT_W-1:0] sq_root_c [SQRT_STG];

  always_comb begin
    logic [SQ_W-1:0]   rad_t;
    logic [REM_W-1:0]  rem_t;
    logic [REM_W-1:0]  raw_t;
    logic [REM_W-1:0]  trial_t;
    logic [ROOT_W-1:0] root_t;
    for (int g = 0; g < SQRT_STG; g++) begin
      rad_t  = s_rad[g];
      rem_t  = s_rem[g];
      root_t = s_root[g];
      for (int k = 0; k < SQRT_PER; k++) begin
        raw_t   = {rem_t[REM_W-3:0], rad_t[SQ_W-1 -: 2]};
        trial_t = REM_W'({root_t, 2'b01});
        rad_t   = rad_t << 2;
        if (raw_t >= trial_t) begin
          rem_t  = raw_t - trial_t;
          root_t = {root_t[ROOT_W-2:0], 1'b1};
        end else begin
          rem_t  = raw_t;
          root_t = {root_t[ROOT_W-2:0], 1'b0};
        end
      end
      sq_rad_c[g]  = rad_t;
      sq_rem_c[g]  = rem_t;
      sq_root_c[g] = root_t;
    end
  end

  // numerator setup: |c|*2^14 + len/2
  logic [ROOT_W-1:0] root_fin;
  logic [NUM_W-1:0]  num_c [3];

  always_comb begin
    root_fin = s_root[SQRT_STG];
    for (int i = 0; i < 3; i++) begin
      num_c[i] = NUM_W'({s_mag[SQRT_STG][i], {FRAC_W{1'b0}}})
               + NUM_W'(root_fin[ROOT_W-1:1]);
    end
  end

  // divider stages, index 0 holds the setup
  logic              v_vld [DIV_STG+1];
  logic              v_nz  [DIV_STG+1];
  logic [2:0]        v_neg [DIV_STG+1];
  logic [ROOT_W-1:0] v_len [DIV_STG+1];
  logic [DREM_W-1:0] v_rem [DIV_STG+1][3];
  logic [QUO_W-1:0]  v_low [DIV_STG+1][3];
  logic [QUO_W-1:0]  v_quo [DIV_STG+1][3];
  logic [DREM_W-1:0] dv_rem_c [DIV_STG][3];
  logic [QUO_W-1:0]  dv_low_c [DIV_STG][3];
  logic [QUO_W-1:0]  dv_quo_c [DIV_STG][3];

  always_comb begin
    logic [DREM_W-1:0] rem_t;
    logic [DREM_W-1:0] raw_t;
    logic [QUO_W-1:0]  low_t;
    logic [QUO_W-1:0]  quo_t;
    for (int g = 0; g < DIV_STG; g++) begin
      for (int i = 0; i < 3; i++) begin
        rem_t = v_rem[g][i];
        low_t = v_low[g][i];
        quo_t = v_quo[g][i];
        for (int k = 0; k < DIV_PER; k++) begin
          raw_t = {rem_t[DREM_W-2:0], low_t[QUO_W-1]};
          low_t = low_t << 1;
          if (raw_t >= DREM_W'(v_len[g])) begin
            rem_t = raw_t - DREM_W'(v_len[g]);
            quo_t = {quo_t[QUO_W-2:0], 1'b1};
          end else begin
            rem_t = raw_t;
            quo_t = {quo_t[QUO_W-2:0], 1'b0};
          end
        end
        dv_rem_c[g][i] = rem_t;
        dv_low_c[g][i] = low_t;
        dv_quo_c[g][i] = quo_t;
      end
    end
  end

  // output stage
  logic f_vld;
  logic f_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      for (int g = 0; g <= SQRT_STG; g++) s_vld[g] <= 1'b0;
      for (int g = 0; g <= DIV_STG; g++) v_vld[g] <= 1'b0;
      f_vld <= 1'b0;
    end else if (ce) begin
      a_vld    <= in_vld;
      b_vld    <= a_vld;
      c_vld    <= b_vld;
      s_vld[0] <= c_vld;
      for (int g = 0; g < SQRT_STG; g++) s_vld[g+1] <= s_vld[g];
      v_vld[0] <= s_vld[SQRT_STG];
      for (int g = 0; g < DIV_STG; g++) v_vld[g+1] <= v_vld[g];
      f_vld <= v_vld[DIV_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= in_vec[i][IN_W-1];
        a_mag[i] <= mag_c[i];
      end
      a_top <= top_c;

      b_nz  <= (a_top != '0);
      b_neg <= a_neg;
      b_mag <= b_mag_c;

      c_nz  <= b_nz;
      c_neg <= b_neg;
      c_mag <= b_mag;
      for (int i = 0; i < 3; i++) c_sq[i] <= b_mag[i] * b_mag[i];

      s_nz[0]   <= c_nz;
      s_neg[0]  <= c_neg;
      s_mag[0]  <= c_mag;
      s_rad[0]  <= SQ_W'(c_sq[0]) + SQ_W'(c_sq[1]) + SQ_W'(c_sq[2]);
      s_rem[0]  <= '0;
      s_root[0] <= '0;
      for (int g = 0; g < SQRT_STG; g++) begin
        s_nz[g+1]   <= s_nz[g];
        s_neg[g+1]  <= s_neg[g];
        s_mag[g+1]  <= s_mag[g];
        s_rad[g+1]  <= sq_rad_c[g];
        s_rem[g+1]  <= sq_rem_c[g];
        s_root[g+1] <= sq_root_c[g];
      end

      v_nz[0]  <= s_nz[SQRT_STG];
      v_neg[0] <= s_neg[SQRT_STG];
      v_len[0] <= root_fin;
      for (int i = 0; i < 3; i++) begin
        v_rem[0][i] <= DREM_W'(num_c[i][NUM_W-1:QUO_W]);
        v_low[0][i] <= num_c[i][QUO_W-1:0];
        v_quo[0][i] <= '0;
      end
      for (int g = 0; g < DIV_STG; g++) begin
        v_nz[g+1]  <= v_nz[g];
        v_neg[g+1] <= v_neg[g];
        v_len[g+1] <= v_len[g];
        v_rem[g+1] <= dv_rem_c[g];
        v_low[g+1] <= dv_low_c[g];
        v_quo[g+1] <= dv_quo_c[g];
      end

      f_nz <= v_nz[DIV_STG];
      for (int i = 0; i < 3; i++) begin
        out_vec[i] <= v_neg[DIV_STG][i] ? -$signed({1'b0, v_quo[DIV_STG][i]})
                                        :  $signed({1'b0, v_quo[DIV_STG][i]});
      end
    end
  end

  always_comb begin
    out_ctl.vld = f_vld;
    out_ctl.nz  = f_nz;
  end

endmodule

`default_nettype wire

/* sv/phong_fragment_shade.sv */
`default_nettype none

// Per-pixel Phong shader. Each input word carries three vertex normals
// (signed Q4.12) and three barycentric weights (Q1.15); each output word is
// one 8-bit gray level (R = G = B). The block interpolates the normal,
// normalizes it, takes diffuse = max(0, n.l), builds r = 2n(n.l) - l,
// normalizes r, raises max(r.z, 0) to the shininess exponent and returns
// floor(255 * min(1, ambient + kd*diffuse + ks*spec)). A zero normal gives
// the ambient term alone. The pipeline accepts one word per clock while it
// is not stalled; its depth is set by the two normalizers (each with 8
// square-root stages and 5 divider stages) and the 63-stage chain of
// exponent multipliers, one multiply per stage for the largest shininess.
// Stalls freeze the whole pipeline only when the output register is full,
// not taken and a word is waiting behind it; bubbles still drain in. The
// light and gain registers are written over cfg_wr_en / cfg_index /
// cfg_data and must only change while the pipeline is empty.
module phong_fragment_shade
  import phf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] normal0_x,
  input  logic signed [15:0] normal0_y,
  input  logic signed [15:0] normal0_z,
  input  logic signed [15:0] normal1_x,
  input  logic signed [15:0] normal1_y,
  input  logic signed [15:0] normal1_z,
  input  logic signed [15:0] normal2_x,
  input  logic signed [15:0] normal2_y,
  input  logic signed [15:0] normal2_z,
  input  logic [15:0]        weight0,
  input  logic [15:0]        weight1,
  input  logic [15:0]        weight2,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         shade_level
);

  localparam int MW    = 35;              // interpolated normal, Q.27
  localparam int RW    = 48;              // reflection vector, Q.42
  localparam int DW    = 32;              // n.l, Q.28
  localparam int DIFFW = DW - 1;
  localparam int PwW   = 2 * QUO_W + 1;
  localparam int SumW  = 33;
  localparam int IntW  = 29;
  localparam logic [SumW-1:0] ClipMax = SumW'(1) << 28;
  localparam logic [PwW-1:0]  PwRound = PwW'(1) << (FRAC_W - 1);
  localparam logic [QUO_W-1:0] PwOne  = QUO_W'(1) << FRAC_W;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic signed [15:0] light [3];
  logic [15:0]        ambient_gain;
  logic [15:0]        diffuse_gain;
  logic [15:0]        specular_gain;
  logic [SHIN_W-1:0]  shininess;

  always_ff @(posedge clk) begin
    if (rst) begin
      light[0]      <= LIGHT_X_RST;
      light[1]      <= LIGHT_Y_RST;
      light[2]      <= LIGHT_Z_RST;
      ambient_gain  <= AMBIENT_RST;
      diffuse_gain  <= DIFFUSE_RST;
      specular_gain <= SPECULAR_RST;
      shininess     <= SHININESS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LIGHT_X:   light[0]      <= cfg_data;
        CFG_LIGHT_Y:   light[1]      <= cfg_data;
        CFG_LIGHT_Z:   light[2]      <= cfg_data;
        CFG_AMBIENT:   ambient_gain  <= cfg_data;
        CFG_DIFFUSE:   diffuse_gain  <= cfg_data;
        CFG_SPECULAR:  specular_gain <= cfg_data;
        CFG_SHININESS: shininess     <= cfg_data[SHIN_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Global advance: hold only when the last stage has a word and the
  // output register is full and not being taken.
  // ---------------------------------------------------------------
  logic advance;
  logic f2_vld;

  assign advance  = !(f2_vld && out_valid && !out_ready);
  assign in_ready = advance;

  logic signed [15:0] nrm_in [3][3];   // [vertex][axis]
  logic [15:0]        wgt_in [3];

  assign nrm_in[0][0] = normal0_x;
  assign nrm_in[0][1] = normal0_y;
  assign nrm_in[0][2] = normal0_z;
  assign nrm_in[1][0] = normal1_x;
  assign nrm_in[1][1] = normal1_y;
  assign nrm_in[1][2] = normal1_z;
  assign nrm_in[2][0] = normal2_x;
  assign nrm_in[2][1] = normal2_y;
  assign nrm_in[2][2] = normal2_z;
  assign wgt_in[0]    = weight0;
  assign wgt_in[1]    = weight1;
  assign wgt_in[2]    = weight2;

  // T1 weighted products, T2 interpolated normal
  logic              t1_vld;
  logic signed [32:0] t1_p [3][3];
  logic              t2_vld;
  logic signed [MW-1:0] t2_m [3];

  // first normalizer: unit normal n
  unit_ctl_t u1_ctl;
  q14_t      u1_vec [3];

  phf_unitize #(
    .IN_W (MW)
  ) u_norm_n (
    .clk     (clk),
    .rst     (rst),
    .ce      (advance),
    .in_vld  (t2_vld),
    .in_vec  (t2_m),
    .out_ctl (u1_ctl),
    .out_vec (u1_vec)
  );

  // T3 n*l products, T4 n.l, T5 reflection vector and diffuse
  logic                  t3_vld;
  logic                  t3_nz;
  q14_t                  t3_n [3];
  logic signed [DW-1:0]  t3_dp [3];
  logic                  t4_vld;
  logic                  t4_nz;
  q14_t                  t4_n [3];
  logic signed [DW-1:0]  t4_d;
  logic signed [RW-1:0]  nd_c [3];
  logic                  t5_vld;
  logic                  t5_nz;
  logic [DIFFW-1:0]      t5_diff;
  logic signed [RW-1:0]  t5_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) nd_c[i] = t4_n[i] * t4_d;
  end

  // second normalizer: unit reflection vector
  unit_ctl_t u2_ctl;
  q14_t      u2_vec [3];

  phf_unitize #(
    .IN_W (RW)
  ) u_norm_r (
    .clk     (clk),
    .rst     (rst),
    .ce      (advance),
    .in_vld  (t5_vld),
    .in_vec  (t5_r),
    .out_ctl (u2_ctl),
    .out_vec (u2_vec)
  );

  // side data riding alongside the second normalizer
  logic             dl_nz   [UNIT_LAT];
  logic [DIFFW-1:0] dl_diff [UNIT_LAT];

  // exponent chain: index 0 is the entry stage, one multiply per stage
  logic             pw_vld  [POW_STG+1];
  logic             pw_ok   [POW_STG+1];
  logic [DIFFW-1:0] pw_diff [POW_STG+1];
  logic [QUO_W-1:0] pw_rz   [POW_STG+1];
  logic [QUO_W-1:0] pw_p    [POW_STG+1];
  logic [QUO_W-1:0] pw_p_c  [POW_STG];

  always_comb begin
    logic [PwW-1:0] prod_t;
    for (int k = 0; k < POW_STG; k++) begin
      prod_t    = PwW'(pw_p[k]) * PwW'(pw_rz[k]) + PwRound;
      pw_p_c[k] = (SHIN_W'(k) < shininess) ? QUO_W'(prod_t >> FRAC_W) : pw_p[k];
    end
  end

  // F1 gain products, F2 sum and clip
  logic [QUO_W-1:0]     spec_c;
  logic                 f1_vld;
  logic [DIFFW+15:0]    f1_pd;
  logic [QUO_W+15:0]    f1_ps;
  logic [SumW-1:0]      sum_c;
  logic [IntW-1:0]      f2_int;
  logic [IntW+7:0]      x255_c;

  assign spec_c = pw_ok[POW_STG] ? pw_p[POW_STG] : '0;
  assign sum_c  = (SumW'(ambient_gain) << 13) + SumW'(f1_pd >> 15) + SumW'(f1_ps >> 1);
  assign x255_c = {f2_int, 8'b0} - (IntW+8)'(f2_int);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld <= 1'b0;
      t2_vld <= 1'b0;
      t3_vld <= 1'b0;
      t4_vld <= 1'b0;
      t5_vld <= 1'b0;
      for (int k = 0; k <= POW_STG; k++) pw_vld[k] <= 1'b0;
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else if (advance) begin
      t1_vld    <= in_valid;
      t2_vld    <= t1_vld;
      t3_vld    <= u1_ctl.vld;
      t4_vld    <= t3_vld;
      t5_vld    <= t4_vld;
      pw_vld[0] <= u2_ctl.vld;
      for (int k = 0; k < POW_STG; k++) pw_vld[k+1] <= pw_vld[k];
      f1_vld    <= pw_vld[POW_STG];
      f2_vld    <= f1_vld;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          t1_p[k][i] <= nrm_in[k][i] * $signed({1'b0, wgt_in[k]});
        end
      end

      for (int i = 0; i < 3; i++) begin
        t2_m[i] <= MW'(t1_p[0][i]) + MW'(t1_p[1][i]) + MW'(t1_p[2][i]);
      end

      t3_nz <= u1_ctl.nz;
      t3_n  <= u1_vec;
      for (int i = 0; i < 3; i++) t3_dp[i] <= u1_vec[i] * light[i];

      t4_nz <= t3_nz;
      t4_n  <= t3_n;
      t4_d  <= t3_dp[0] + t3_dp[1] + t3_dp[2];

      // r = 2 n (n.l) - l, all in Q.42
      t5_nz   <= t4_nz;
      t5_diff <= (t4_nz && t4_d > 0) ? t4_d[DIFFW-1:0] : '0;
      for (int i = 0; i < 3; i++) begin
        t5_r[i] <= (nd_c[i] <<< 1) - (RW'(light[i]) <<< 28);
      end

      dl_nz[0]   <= t5_nz;
      dl_diff[0] <= t5_diff;
      for (int k = 1; k < UNIT_LAT; k++) begin
        dl_nz[k]   <= dl_nz[k-1];
        dl_diff[k] <= dl_diff[k-1];
      end

      // spec base max(r.z, 0); starts at 1.0
      pw_ok[0]   <= dl_nz[UNIT_LAT-1] && u2_ctl.nz;
      pw_diff[0] <= dl_diff[UNIT_LAT-1];
      pw_rz[0]   <= (u2_vec[2] > 0) ? u2_vec[2][QUO_W-1:0] : '0;
      pw_p[0]    <= PwOne;
      for (int k = 0; k < POW_STG; k++) begin
        pw_ok[k+1]   <= pw_ok[k];
        pw_diff[k+1] <= pw_diff[k];
        pw_rz[k+1]   <= pw_rz[k];
        pw_p[k+1]    <= pw_p_c[k];
      end

      f1_pd <= diffuse_gain * pw_diff[POW_STG];
      f1_ps <= specular_gain * spec_c;

      f2_int <= (sum_c > ClipMax) ? IntW'(ClipMax) : IntW'(sum_c);
    end
  end

  // output register: level = (I * 255) >> 28
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && f2_vld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && f2_vld) begin
      shade_level <= x255_c[IntW+6:IntW-1];
    end
  end

endmodule

`default_nettype wire

/* sv/phf_check.sv */
`default_nettype none

`include "phong_fragment_shade_defines.svh"

module phf_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] shade_level
);

  // stalled output word holds
  `PHF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(shade_level), "output word changed while stalled")

  // input side never blocks while the output register is free or draining
  `PHF_ASSERT_SAME(a_ready_free, !out_valid || out_ready, in_ready, "input stalled with output free")

  // pipeline comes out of reset empty
  `PHF_ASSERT_SAME(a_reset_empty, $past(rst), !out_valid, "output word right after reset")

endmodule

bind phong_fragment_shade phf_check u_check (.*);

`default_nettype wire

/* tb/sv/phf_shade_checker.sv */
`default_nettype none

module phf_shade_checker
  import phf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] normal0_x,
  input  logic signed [15:0] normal0_y,
  input  logic signed [15:0] normal0_z,
  input  logic signed [15:0] normal1_x,
  input  logic signed [15:0] normal1_y,
  input  logic signed [15:0] normal1_z,
  input  logic signed [15:0] normal2_x,
  input  logic signed [15:0] normal2_y,
  input  logic signed [15:0] normal2_z,
  input  logic [15:0]        weight0,
  input  logic [15:0]        weight1,
  input  logic [15:0]        weight2,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         shade_level,
  output int                 fail_count,
  output int                 levels_pending
);

  // shadow copy of the light and gain registers
  logic signed [15:0] lgt [3];
  logic [15:0]        amb_g, dif_g, spc_g;
  logic [SHIN_W-1:0]  shin;

  logic [7:0] level_q[$];

  assign levels_pending = level_q.size();

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // scale to Q2.14 unit length; returns 0 for the zero vector
  function automatic bit to_unit(input longint v[3], output longint u[3]);
    longint unsigned mag[3], top, sq, len, q;
    top = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) return 0;
    while (top >= (64'd1 << 23)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (top < (64'd1 << 22)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
    len = root64(sq);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + len / 2) / len;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic logic [7:0] shade_of(input longint nv[3][3], input longint w[3]);
    longint m[3], n[3], r[3], ru[3], d;
    longint unsigned diff, spec, rz, p, inten;
    diff = 0;
    spec = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = 0;
      for (int k = 0; k < 3; k++) m[i] += nv[k][i] * w[k];
    end
    if (to_unit(m, n)) begin
      d = 0;
      for (int i = 0; i < 3; i++) d += n[i] * longint'(lgt[i]);
      if (d > 0) diff = d;
      for (int i = 0; i < 3; i++) r[i] = 2 * n[i] * d - longint'(lgt[i]) * (64'sd1 <<< 28);
      if (to_unit(r, ru)) begin
        rz = (ru[2] > 0) ? ru[2] : 0;
        p = 16384;
        for (int e = 0; e < shin; e++) p = (p * rz + 8192) >> 14;
        spec = p;
      end
    end
    inten = (longint'(amb_g) << 13) + ((longint'(dif_g) * diff) >> 15)
          + ((longint'(spc_g) * spec) >> 1);
    if (inten > (64'd1 << 28)) inten = 64'd1 << 28;
    return 8'((inten * 255) >> 28);
  endfunction

  always @(posedge clk) begin
    longint nv[3][3], w[3];
    logic [7:0] want;
    if (rst) begin
      lgt[0] <= LIGHT_X_RST;
      lgt[1] <= LIGHT_Y_RST;
      lgt[2] <= LIGHT_Z_RST;
      amb_g <= AMBIENT_RST;
      dif_g <= DIFFUSE_RST;
      spc_g <= SPECULAR_RST;
      shin <= SHININESS_RST;
      fail_count <= 0;
      level_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LIGHT_X:   lgt[0] <= cfg_data;
          CFG_LIGHT_Y:   lgt[1] <= cfg_data;
          CFG_LIGHT_Z:   lgt[2] <= cfg_data;
          CFG_AMBIENT:   amb_g <= cfg_data;
          CFG_DIFFUSE:   dif_g <= cfg_data;
          CFG_SPECULAR:  spc_g <= cfg_data;
          CFG_SHININESS: shin <= cfg_data[SHIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        nv[0] = '{normal0_x, normal0_y, normal0_z};
        nv[1] = '{normal1_x, normal1_y, normal1_z};
        nv[2] = '{normal2_x, normal2_y, normal2_z};
        w = '{weight0, weight1, weight2};
        level_q.push_back(shade_of(nv, w));
      end
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          $display("%0t: unexpected word, shade_level %0d", $time, shade_level);
          fail_count <= fail_count + 1;
        end else begin
          want = level_q.pop_front();
          if (want !== shade_level) begin
            $display("%0t: shade_level expected %0d actual %0d", $time, want, shade_level);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_phong_fragment_shade.sv */
`default_nettype none

module tb_phong_fragment_shade;
  import phf_pkg::*;

  localparam int DRAIN = 150;   // pipeline depth is 110, leave margin

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] nrm [9];
  logic [15:0] wgt [3];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] shade_level;
  int fail_count, levels_pending;

  initial begin
    for (int i = 0; i < 9; i++) nrm[i] = '0;
    for (int i = 0; i < 3; i++) wgt[i] = '0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  phong_fragment_shade i_dut (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .normal0_x(nrm[0]), .normal0_y(nrm[1]), .normal0_z(nrm[2]),
    .normal1_x(nrm[3]), .normal1_y(nrm[4]), .normal1_z(nrm[5]),
    .normal2_x(nrm[6]), .normal2_y(nrm[7]), .normal2_z(nrm[8]),
    .weight0(wgt[0]), .weight1(wgt[1]), .weight2(wgt[2]),
    .out_valid, .out_ready, .shade_level
  );

  phf_shade_checker u_chk (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .normal0_x(nrm[0]), .normal0_y(nrm[1]), .normal0_z(nrm[2]),
    .normal1_x(nrm[3]), .normal1_y(nrm[4]), .normal1_z(nrm[5]),
    .normal2_x(nrm[6]), .normal2_y(nrm[7]), .normal2_z(nrm[8]),
    .weight0(wgt[0]), .weight1(wgt[1]), .weight2(wgt[2]),
    .out_valid, .out_ready, .shade_level,
    .fail_count, .levels_pending
  );

  // Receiver: random stall per word, sometimes long bursts of always-ready.
  initial begin
    int gap;
    bit eager;
    @(posedge clk iff !rst);
    forever begin
      eager = ($urandom_range(0, 3) == 0);
      repeat (50) begin
        gap = eager ? 0 : $urandom_range(0, 19);
        repeat (gap) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk iff out_valid);
      end
    end
  end

  // One write, then cfg_wr_en is lowered and the task idles before returning, so back-to-back writes never collide.
  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Present one fragment; sender gap drawn per word unless told not to idle.
  // Valid stays up after the handshake; the next gap or a drain drops it.
  task automatic send_fragment(input logic signed [15:0] n[9], input logic [15:0] w[3],
                               input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) nrm[i] <= n[i];
    for (int i = 0; i < 3; i++) wgt[i] <= w[i];
    @(posedge clk iff in_ready);
  endtask

  // Wait for every predicted level, then for the pipeline to settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk iff levels_pending == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_unit_axis();
    case ($urandom_range(0, 4))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom_range(0, 32768)) - 16'd16384;
      3: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly realistic normals and weights summing near 1.0, some raw noise.
  task automatic random_fragment(input bit no_gap);
    logic signed [15:0] n[9];
    logic [15:0] w[3];
    int a, b;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 9; i++) n[i] = 16'($urandom);
      for (int i = 0; i < 3; i++) begin
        w[i] = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 32768));
      end
    end else begin
      for (int i = 0; i < 9; i++) n[i] = 16'($urandom_range(0, 8192)) - 16'd4096;
      a = $urandom_range(0, 32768);
      b = $urandom_range(0, 32768 - a);
      w = '{16'(a), 16'(b), 16'(32768 - a - b)};
    end
    send_fragment(n, w, no_gap);
  endtask

  initial begin
    logic signed [15:0] n[9];
    logic [15:0] w[3];
    bit burst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset settings: field extremes, zero normal, axis normals.
    n = '{default: 16'sh7FFF}; w = '{16'd32768, 16'd0, 16'd0};
    send_fragment(n, w, 0);
    n = '{default: 16'sh8000}; w = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_fragment(n, w, 0);
    n = '{default: 16'sd0}; w = '{16'd10000, 16'd10000, 16'd12768};
    send_fragment(n, w, 0);     // zero normal: ambient alone
    n = '{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096};
    w = '{16'd32768, 16'd0, 16'd0};
    send_fragment(n, w, 0);     // normal on the light: full highlight
    n = '{16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0};
    send_fragment(n, w, 1);     // grazing
    n = '{16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, -16'sd4096};
    send_fragment(n, w, 1);     // back facing
    n = '{16'sd4096, 16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    w = '{16'd16384, 16'd16384, 16'd0};
    send_fragment(n, w, 0);     // weights cancel to zero normal
    n = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    w = '{16'd1, 16'd0, 16'd0};
    send_fragment(n, w, 0);     // smallest nonzero normal
    drain();

    // Zero light: reflection vanishes whenever n.l is zero.
    cfg_write(CFG_LIGHT_Z, 16'd0);
    cfg_write(CFG_SHININESS, 16'd0);
    n = '{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096};
    w = '{16'd32768, 16'd0, 16'd0};
    send_fragment(n, w, 0);
    drain();
    // Gains and exponent at their extremes, high bits of the exponent ignored.
    cfg_write(CFG_LIGHT_Z, 16'sd16384);
    cfg_write(CFG_AMBIENT, 16'd32768);
    cfg_write(CFG_DIFFUSE, 16'hFFFF);
    cfg_write(CFG_SPECULAR, 16'hFFFF);
    cfg_write(CFG_SHININESS, 16'hFFC0);   // shininess zero: spec is 1.0
    for (int i = 0; i < 4; i++) random_fragment(0);
    drain();
    cfg_write(CFG_AMBIENT, 16'd0);
    cfg_write(CFG_DIFFUSE, 16'd0);
    cfg_write(CFG_SPECULAR, 16'd0);
    cfg_write(CFG_SHININESS, 16'd63);
    for (int i = 0; i < 4; i++) random_fragment(0);
    drain();

    // Random phases: new light and gains each phase, extremes mixed in.
    for (int ph = 0; ph < 25; ph++) begin
      cfg_write(CFG_LIGHT_X, rand_unit_axis());
      cfg_write(CFG_LIGHT_Y, rand_unit_axis());
      cfg_write(CFG_LIGHT_Z, rand_unit_axis());
      cfg_write(CFG_AMBIENT, $urandom_range(0, 2) == 0 ? 16'($urandom)
                                                        : 16'($urandom_range(0, 16384)));
      cfg_write(CFG_DIFFUSE, $urandom_range(0, 2) == 0 ? 16'($urandom)
                                                        : 16'($urandom_range(0, 32768)));
      cfg_write(CFG_SPECULAR, $urandom_range(0, 2) == 0 ? 16'($urandom)
                                                         : 16'($urandom_range(0, 32768)));
      cfg_write(CFG_SHININESS, 16'($urandom));
      burst = (ph % 3 == 0);    // back-to-back words on some phases
      for (int i = 0; i < 70; i++) random_fragment(burst);
      drain();   // also the pause until every level has come back
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
